// ===== hw/rtl/bmpu_pkg.sv =====
package bmpu_pkg;

    localparam int DIM_W   = 13;
    localparam int MASK_W  = 16;
    localparam int CHAN_W  = 8;
    localparam int COORD_W = 12;
    localparam int NUM_CH  = 4;

    // channel slots in the mask and field-format arrays
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    typedef enum logic [1:0] {
        MODE_GREY8 = 2'd0,
        MODE_RGB16 = 2'd1,
        MODE_BGR24 = 2'd2,
        MODE_NONE  = 2'd3
    } t_pixel_mode;

    typedef enum logic [2:0] {
        CFG_PIXEL_MODE    = 3'd0,
        CFG_IMAGE_WIDTH   = 3'd1,
        CFG_IMAGE_HEIGHT  = 3'd2,
        CFG_USE_BITFIELDS = 3'd3,
        CFG_RED_MASK      = 3'd4,
        CFG_GREEN_MASK    = 3'd5,
        CFG_BLUE_MASK     = 3'd6,
        CFG_ALPHA_MASK    = 3'd7
    } t_cfg_index;

    // decoded bit field of one channel mask
    typedef struct packed {
        logic       zero;
        logic [3:0] shift;
        logic [4:0] len;
    } t_chan_fmt;

    typedef struct packed {
        t_pixel_mode                   mode;
        logic [DIM_W-1:0]              width;   // already clamped
        logic [DIM_W-1:0]              height;  // already clamped
        logic                          use_bitfields;
        logic [NUM_CH-1:0][MASK_W-1:0] mask;
        t_chan_fmt [NUM_CH-1:0]        fmt;
    } t_cfg;

    // one assembled pixel with its position
    typedef struct packed {
        t_pixel_mode        mode;
        logic [7:0]         last_byte;
        logic [15:0]        store;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_pix_rec;

endpackage

// ===== hw/rtl/bmpu_cfg_regs.sv =====
module bmpu_cfg_regs
    import bmpu_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [2:0]        i_index,
    input  logic [MASK_W-1:0] i_wdata,
    output t_cfg              o_cfg
);

    function automatic t_chan_fmt chan_fmt(input logic [MASK_W-1:0] m);
        t_chan_fmt        f;
        logic [MASK_W-1:0] run;
        int               i;
        f.zero  = (m == '0);
        f.shift = 4'd0;
        for (i = MASK_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                f.shift = 4'(i);
            end
        end
        run   = m >> f.shift;
        f.len = 5'd16;
        for (i = MASK_W - 1; i >= 0; i--) begin
            if (!run[i]) begin
                f.len = 5'(i);
            end
        end
        return f;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'({19'd0, v}) > maxv) begin
            res = DIM_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (t_cfg_index'(i_index))
                CFG_PIXEL_MODE:    n_cfg.mode          = t_pixel_mode'(i_wdata[1:0]);
                CFG_IMAGE_WIDTH:   n_cfg.width         = clamp_dim(i_wdata[DIM_W-1:0], MAX_WIDTH);
                CFG_IMAGE_HEIGHT:  n_cfg.height        = clamp_dim(i_wdata[DIM_W-1:0], MAX_HEIGHT);
                CFG_USE_BITFIELDS: n_cfg.use_bitfields = i_wdata[0];
                CFG_RED_MASK: begin
                    n_cfg.mask[CH_RED] = i_wdata;
                    n_cfg.fmt[CH_RED]  = chan_fmt(i_wdata);
                end
                CFG_GREEN_MASK: begin
                    n_cfg.mask[CH_GREEN] = i_wdata;
                    n_cfg.fmt[CH_GREEN]  = chan_fmt(i_wdata);
                end
                CFG_BLUE_MASK: begin
                    n_cfg.mask[CH_BLUE] = i_wdata;
                    n_cfg.fmt[CH_BLUE]  = chan_fmt(i_wdata);
                end
                CFG_ALPHA_MASK: begin
                    n_cfg.mask[CH_ALPHA] = i_wdata;
                    n_cfg.fmt[CH_ALPHA]  = chan_fmt(i_wdata);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= MODE_BGR24;
            r_cfg.width          <= DIM_W'(1);
            r_cfg.height         <= DIM_W'(1);
            r_cfg.use_bitfields  <= 1'b0;
            r_cfg.mask[CH_RED]   <= 16'h7C00;
            r_cfg.mask[CH_GREEN] <= 16'h03E0;
            r_cfg.mask[CH_BLUE]  <= 16'h001F;
            r_cfg.mask[CH_ALPHA] <= 16'h0000;
            r_cfg.fmt[CH_RED]    <= chan_fmt(16'h7C00);
            r_cfg.fmt[CH_GREEN]  <= chan_fmt(16'h03E0);
            r_cfg.fmt[CH_BLUE]   <= chan_fmt(16'h001F);
            r_cfg.fmt[CH_ALPHA]  <= chan_fmt(16'h0000);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/bmpu_assembler.sv =====
module bmpu_assembler
    import bmpu_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_image_start,
    output logic       o_stall,
    input  logic       i_rec_take,
    output logic       o_rec_valid,
    output t_pix_rec   o_rec
);

    localparam int COL_W = ($clog2(MAX_WIDTH) < DIM_W) ? $clog2(MAX_WIDTH) : DIM_W;
    localparam int ROW_W = ($clog2(MAX_HEIGHT) < DIM_W) ? $clog2(MAX_HEIGHT) : DIM_W;

    // bytes of padding after a row of w pixels
    function automatic logic [1:0] pad_bytes(input logic [1:0] w_lo, input t_pixel_mode mode);
        logic [1:0] res;
        case (mode)
            MODE_GREY8: res = 2'(2'd0 - w_lo);
            MODE_RGB16: res = 2'(2'd0 - {w_lo[0], 1'b0});
            MODE_BGR24: res = w_lo;
            default:    res = 2'd0;
        endcase
        return res;
    endfunction

    logic [15:0]      r_store, n_store;
    logic [1:0]       r_pos, n_pos;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [1:0]       r_pad, n_pad;
    logic             r_rec_valid, n_rec_valid;
    t_pix_rec         r_rec, n_rec;

    logic             accept;
    logic [1:0]       e_pos;
    logic [COL_W-1:0] e_col;
    logic [ROW_W-1:0] e_row;
    logic [1:0]       e_pad;
    logic [DIM_W-1:0] row_ext;
    logic [DIM_W-1:0] row_val;
    logic             last_col;
    logic             last_row;

    assign o_stall = r_rec_valid && !i_rec_take;
    assign accept  = i_valid && !o_stall;

    // image start clears the counters before the byte is used
    assign e_pos = i_image_start ? 2'd0 : r_pos;
    assign e_col = i_image_start ? '0 : r_col;
    assign e_row = i_image_start ? '0 : r_row;
    assign e_pad = i_image_start ? 2'd0 : r_pad;

    assign row_ext  = DIM_W'(e_row);
    assign row_val  = (row_ext < i_cfg.height) ? (i_cfg.height - DIM_W'(1) - row_ext) : '0;
    assign last_col = ({1'b0, DIM_W'(e_col)} + (DIM_W+1)'(1)) >= {1'b0, i_cfg.width};
    assign last_row = ({1'b0, row_ext} + (DIM_W+1)'(1)) >= {1'b0, i_cfg.height};

    always_comb begin
        n_store     = r_store;
        n_pos       = r_pos;
        n_col       = r_col;
        n_row       = r_row;
        n_pad       = r_pad;
        n_rec_valid = r_rec_valid && !i_rec_take;
        n_rec       = r_rec;
        if (accept) begin
            n_pos = e_pos;
            n_col = e_col;
            n_row = e_row;
            n_pad = e_pad;
            if (i_cfg.mode != MODE_NONE) begin
                if (e_pad != 2'd0) begin
                    n_pad = e_pad - 2'd1;
                end else if (e_pos < 2'(i_cfg.mode)) begin
                    n_store = (e_pos == 2'd0) ? {8'd0, i_data_byte}
                                              : {i_data_byte, r_store[7:0]};
                    n_pos   = e_pos + 2'd1;
                end else begin
                    n_pos           = 2'd0;
                    n_rec_valid     = 1'b1;
                    n_rec.mode      = i_cfg.mode;
                    n_rec.last_byte = i_data_byte;
                    n_rec.store     = r_store;
                    n_rec.column    = COORD_W'(e_col);
                    n_rec.row       = COORD_W'(row_val);
                    n_rec.last      = last_col && last_row;
                    if (last_col) begin
                        n_col = '0;
                        n_pad = pad_bytes(i_cfg.width[1:0], i_cfg.mode);
                        n_row = last_row ? '0 : e_row + ROW_W'(1);
                    end else begin
                        n_col = e_col + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 2'd0;
            r_col       <= '0;
            r_row       <= '0;
            r_pad       <= 2'd0;
            r_rec_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pad       <= n_pad;
            r_rec_valid <= n_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        r_rec   <= n_rec;
    end

    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 2'd3)
        else $error("byte position out of range");

    a_pad_at_pixel_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad != 2'd0) |-> (r_pos == 2'd0))
        else $error("row padding pending inside a pixel");

    a_last_on_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rec_valid && r_rec.last) |-> (r_rec.row == '0))
        else $error("final pixel not on row zero");

    a_rec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rec_valid && !i_rec_take) |=> (r_rec_valid && $stable(r_rec)))
        else $error("pixel record lost while downstream busy");

endmodule

// ===== hw/rtl/bmpu_color.sv =====
module bmpu_color
    import bmpu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_rec_valid,
    input  t_pix_rec           i_rec,
    output logic               o_rec_take,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CHAN_W-1:0]  o_red,
    output logic [CHAN_W-1:0]  o_green,
    output logic [CHAN_W-1:0]  o_blue,
    output logic [CHAN_W-1:0]  o_alpha,
    output logic [COORD_W-1:0] o_column,
    output logic [COORD_W-1:0] o_row,
    output logic               o_last_pixel
);

    // field at the mask, scaled to 8 bits (top bits kept when wider)
    function automatic logic [CHAN_W-1:0] extract(input logic [MASK_W-1:0] pix,
                                                  input logic [MASK_W-1:0] mask,
                                                  input t_chan_fmt fmt);
        logic [MASK_W-1:0] s;
        logic [CHAN_W-1:0] v;
        s = (pix & mask) >> fmt.shift;
        if (fmt.zero) begin
            v = '0;
        end else if (fmt.len <= 5'd8) begin
            v = CHAN_W'(s << (5'd8 - fmt.len));
        end else begin
            v = CHAN_W'(s >> (fmt.len - 5'd8));
        end
        return v;
    endfunction

    logic              r_valid, n_valid;
    logic [CHAN_W-1:0] n_red, n_green, n_blue, n_alpha;
    logic [CHAN_W-1:0] r_red, r_green, r_blue, r_alpha;
    logic [COORD_W-1:0] r_column, r_row;
    logic              r_last;
    logic [MASK_W-1:0] pix;

    assign o_rec_take = i_rec_valid && (!r_valid || !i_stall);
    assign n_valid    = o_rec_take || (r_valid && i_stall);
    assign pix        = {i_rec.last_byte, i_rec.store[7:0]};

    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        n_alpha = 8'hFF;
        case (i_rec.mode)
            MODE_GREY8: begin
                n_red   = i_rec.last_byte;
                n_green = i_rec.last_byte;
                n_blue  = i_rec.last_byte;
            end
            MODE_RGB16: begin
                if (i_cfg.use_bitfields) begin
                    n_red   = extract(pix, i_cfg.mask[CH_RED],   i_cfg.fmt[CH_RED]);
                    n_green = extract(pix, i_cfg.mask[CH_GREEN], i_cfg.fmt[CH_GREEN]);
                    n_blue  = extract(pix, i_cfg.mask[CH_BLUE],  i_cfg.fmt[CH_BLUE]);
                    if (!i_cfg.fmt[CH_ALPHA].zero) begin
                        n_alpha = extract(pix, i_cfg.mask[CH_ALPHA], i_cfg.fmt[CH_ALPHA]);
                    end
                end else begin
                    n_blue  = {pix[4:0], 3'd0};
                    n_green = {pix[9:5], 3'd0};
                    n_red   = {pix[14:10], 3'd0};
                end
            end
            MODE_BGR24: begin
                n_blue  = i_rec.store[7:0];
                n_green = i_rec.store[15:8];
                n_red   = i_rec.last_byte;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_take) begin
            r_red    <= n_red;
            r_green  <= n_green;
            r_blue   <= n_blue;
            r_alpha  <= n_alpha;
            r_column <= i_rec.column;
            r_row    <= i_rec.row;
            r_last   <= i_rec.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_alpha      = r_alpha;
    assign o_column     = r_column;
    assign o_row        = r_row;
    assign o_last_pixel = r_last;

endmodule

// ===== hw/rtl/bmp_pixel_unpacker_unit.sv =====
// Bitmap pixel-array unpacker: bytes in, RGBA8888 pixels with position out.
// Input channel: i_valid / o_stall carry one pixel-array byte per request
//   (i_data_byte) plus i_image_start, which flags the first byte of an image
//   and restarts the byte, column, row and padding counters.
// Output channel: o_valid / i_stall carry one pixel per request: RGBA, column,
//   row (bottom-up: first row out is height-1) and o_last_pixel.
// Config: i_cfg_we / i_cfg_index / i_cfg_wdata, write-only, one register per
//   edge; write only while no request is in flight. Width and height are
//   clamped to 1..MAX_WIDTH / 1..MAX_HEIGHT on write; mask fields (shift and
//   length) are decoded on write.
// Pipeline: byte assembly + counters -> pixel register -> color decode ->
//   output register. A pixel's final byte goes to the pixel register, then
//   to the output register unless stalled. Throughput: one byte per cycle
//   while o_stall is low; a pixel every 1, 2 or 3 bytes, padding gives none.
// Reset (sync, active low): config returns to 24-bit BGR, 1x1, 5-5-5 masks;
//   counters clear and the pipeline empties.
// Stall: with the output held, the pixel register still fills; once it is
//   full and the output is stalled, o_stall rises in the same cycle.
module bmp_pixel_unpacker_unit
    import bmpu_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [MASK_W-1:0]  i_cfg_wdata,
    // byte stream in
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_image_start,
    // pixels out
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CHAN_W-1:0]  o_red,
    output logic [CHAN_W-1:0]  o_green,
    output logic [CHAN_W-1:0]  o_blue,
    output logic [CHAN_W-1:0]  o_alpha,
    output logic [COORD_W-1:0] o_column,
    output logic [COORD_W-1:0] o_row,
    output logic               o_last_pixel
);

    t_cfg     cfg;
    logic     rec_valid;
    logic     rec_take;
    t_pix_rec rec;

    bmpu_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // assembles bytes into pixels, tracks column/row, skips row padding
    bmpu_assembler #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_asm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .i_data_byte   (i_data_byte),
        .i_image_start (i_image_start),
        .o_stall       (o_stall),
        .i_rec_take    (rec_take),
        .o_rec_valid   (rec_valid),
        .o_rec         (rec)
    );

    // grey / 5-5-5 / bitfield / BGR to RGBA, output register
    bmpu_color u_color (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_rec_valid  (rec_valid),
        .i_rec        (rec),
        .o_rec_take   (rec_take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_column     (o_column),
        .o_row        (o_row),
        .o_last_pixel (o_last_pixel)
    );

endmodule

// ===== tb/tb_bmp_pixel_unpacker_unit.sv =====
`timescale 1ns / 1ps

module tb_bmp_pixel_unpacker_unit
    import bmpu_pkg::*;
;

    localparam int MAX_DIM      = 4096;  // matches the DUT parameter defaults
    localparam int DRAIN_CYCLES = 8;     // pipeline depth plus margin after the last pixel
    localparam int RANDOM_BYTES = 600;

    // 5-5-5 masks the block comes out of reset with
    localparam logic [15:0] RED_555   = 16'h7C00;
    localparam logic [15:0] GREEN_555 = 16'h03E0;
    localparam logic [15:0] BLUE_555  = 16'h001F;

    // one decoded pixel, field order matches the output ports
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
    } t_rgba_pixel;

    // Tracks the register file and the byte/column/row/padding counters, turns
    // every accepted byte request into zero or one expected pixel, and checks
    // pixels as they leave the block.
    class pixel_scoreboard;
        t_pixel_mode  mode;
        logic [12:0]  width_raw;
        logic [12:0]  height_raw;
        logic         bitfields;
        logic [15:0]  chan_mask [NUM_CH];

        logic [15:0]  store;
        int           pos;
        int           col_cnt;
        int           row_cnt;
        int           pad_left;

        t_rgba_pixel  pixels_due [$];
        int unsigned  errors;

        function new();
            mode                = MODE_BGR24;
            width_raw           = 13'd1;
            height_raw          = 13'd1;
            bitfields           = 1'b0;
            chan_mask[CH_RED]   = RED_555;
            chan_mask[CH_GREEN] = GREEN_555;
            chan_mask[CH_BLUE]  = BLUE_555;
            chan_mask[CH_ALPHA] = 16'h0000;
            store               = 16'h0000;
            pos                 = 0;
            col_cnt             = 0;
            row_cnt             = 0;
            pad_left            = 0;
            errors              = 0;
        endfunction

        // zero counts as 1, anything past the maximum saturates
        function int clamp_dim(logic [12:0] v);
            if (v == 13'd0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return int'(v);
        endfunction

        function int width_px();
            return clamp_dim(width_raw);
        endfunction

        function int height_px();
            return clamp_dim(height_raw);
        endfunction

        function int bytes_per_pixel();
            return int'(mode) + 1;
        endfunction

        // bytes that round a row up to a multiple of four
        function int row_pad();
            return (4 - ((width_px() * bytes_per_pixel()) & 3)) & 3;
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] d);
            case (idx)
                CFG_PIXEL_MODE:    mode = t_pixel_mode'(d[1:0]);
                CFG_IMAGE_WIDTH:   width_raw = d[12:0];
                CFG_IMAGE_HEIGHT:  height_raw = d[12:0];
                CFG_USE_BITFIELDS: bitfields = d[0];
                CFG_RED_MASK:      chan_mask[CH_RED] = d;
                CFG_GREEN_MASK:    chan_mask[CH_GREEN] = d;
                CFG_BLUE_MASK:     chan_mask[CH_BLUE] = d;
                CFG_ALPHA_MASK:    chan_mask[CH_ALPHA] = d;
                default: ;
            endcase
        endfunction

        // channel from a mask: shift to the lowest set bit, run length from
        // there; short fields scale up, long ones keep their top 8 bits
        function logic [7:0] field_value(logic [15:0] pix, logic [15:0] m);
            int          sh;
            int          len;
            logic [31:0] v;
            if (m == 16'h0000) return 8'h00;
            sh = 0;
            while (sh < 16 && !m[sh]) sh++;
            len = 0;
            while (sh + len < 16 && m[sh + len]) len++;
            v = 32'(pix & m) >> sh;
            if (len <= 8) return 8'(v << (8 - len));
            return 8'(v >> (len - 8));
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            int          w;
            int          h;
            int          bpp;
            logic [15:0] pix;
            logic        end_col;
            logic        end_row;
            t_rgba_pixel px;
            w = width_px();
            h = height_px();
            if (start) begin
                store    = 16'h0000;
                pos      = 0;
                col_cnt  = 0;
                row_cnt  = 0;
                pad_left = 0;
            end
            if (mode == MODE_NONE) return;
            if (pad_left != 0) begin
                pad_left--;
                return;
            end
            bpp = bytes_per_pixel();
            if (pos + 1 < bpp) begin
                store = (pos == 0) ? {8'h00, b} : {b, store[7:0]};
                pos++;
                return;
            end
            pos = 0;

            px.alpha = 8'hFF;
            case (mode)
                MODE_GREY8: begin
                    px.red   = b;
                    px.green = b;
                    px.blue  = b;
                end
                MODE_RGB16: begin
                    pix = {b, store[7:0]};
                    if (bitfields) begin
                        px.red   = field_value(pix, chan_mask[CH_RED]);
                        px.green = field_value(pix, chan_mask[CH_GREEN]);
                        px.blue  = field_value(pix, chan_mask[CH_BLUE]);
                        if (chan_mask[CH_ALPHA] != 16'h0000)
                            px.alpha = field_value(pix, chan_mask[CH_ALPHA]);
                    end else begin
                        px.blue  = {pix[4:0], 3'b000};
                        px.green = {pix[9:5], 3'b000};
                        px.red   = {pix[14:10], 3'b000};
                    end
                end
                default: begin
                    px.blue  = store[7:0];
                    px.green = store[15:8];
                    px.red   = b;
                end
            endcase

            px.column = 12'(col_cnt);
            px.row    = (row_cnt < h) ? 12'(h - 1 - row_cnt) : 12'd0;
            end_col   = (col_cnt + 1 >= w);
            end_row   = (row_cnt + 1 >= h);
            if (end_col) begin
                col_cnt  = 0;
                pad_left = row_pad();
                row_cnt  = end_row ? 0 : row_cnt + 1;
            end else begin
                col_cnt++;
            end
            px.last = end_col && end_row;
            pixels_due.push_back(px);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(t_rgba_pixel got);
            t_rgba_pixel want;
            if (pixels_due.size() == 0) begin
                $error("pixel with none outstanding: column %0d row %0d",
                       got.column, got.row);
                errors++;
                return;
            end
            want = pixels_due.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("column", want.column, got.column);
            compare_field("row", want.row, got.row);
            compare_field("last_pixel", want.last, got.last);
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // DUT signals
    // ---------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [MASK_W-1:0]  i_cfg_wdata;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_data_byte;
    logic               i_image_start;
    logic               o_valid;
    logic               i_stall;
    logic [CHAN_W-1:0]  o_red;
    logic [CHAN_W-1:0]  o_green;
    logic [CHAN_W-1:0]  o_blue;
    logic [CHAN_W-1:0]  o_alpha;
    logic [COORD_W-1:0] o_column;
    logic [COORD_W-1:0] o_row;
    logic               o_last_pixel;

    t_rgba_pixel        seen_px;
    pixel_scoreboard    pix_sb;
    bit                 no_gaps = 1'b0;  // both sides run back to back while set
    int                 bytes_sent = 0;

    bmp_pixel_unpacker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_image_start (i_image_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_last_pixel  (o_last_pixel)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    assign seen_px = {o_red, o_green, o_blue, o_alpha, o_column, o_row, o_last_pixel};

    // All sampling happens right at the rising edge, before any NBA of that
    // edge lands, so every read sees the values the DUT registered on.
    // Config writes never share an edge with byte requests.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                pix_sb.write_reg(i_cfg_index, i_cfg_wdata);
            if (i_valid && !o_stall)
                pix_sb.take_byte(i_data_byte, i_image_start);
            if (o_valid && !i_stall)
                pix_sb.check_pixel(seen_px);
        end
    end

    // Receiver: before each pixel request, hold stall for a random span (none
    // while no_gaps is set), then drop it and take whatever comes next.
    initial begin
        int hold;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = no_gaps ? 0 : $urandom_range(0, 17);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------

    // One byte request after a random gap. Valid stays high into the next
    // request when the next gap is zero, so it is only ever assigned once per
    // edge.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_image_start <= start;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop sending, wait for every outstanding pixel, then let the pipeline
    // settle (padding bytes may still be in flight with nothing to show).
    // The first edge lets the scoreboard log the byte accepted on the edge
    // the caller returned from.
    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pix_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all eight registers back to back; only called while idle.
    // Bits above a register's width carry noise, the block must drop them.
    task automatic load_config(input t_pixel_mode mode, input logic [15:0] width_w,
                               input logic [15:0] height_w, input logic bf,
                               input logic [15:0] red_m, input logic [15:0] green_m,
                               input logic [15:0] blue_m, input logic [15:0] alpha_m);
        logic [15:0] vals [8];
        logic [15:0] noise;
        noise                     = 16'($urandom);
        vals[CFG_PIXEL_MODE]      = {noise[15:2], mode};
        vals[CFG_IMAGE_WIDTH]     = width_w;
        vals[CFG_IMAGE_HEIGHT]    = height_w;
        vals[CFG_USE_BITFIELDS]   = {noise[14:0], bf};
        vals[CFG_RED_MASK]        = red_m;
        vals[CFG_GREEN_MASK]      = green_m;
        vals[CFG_BLUE_MASK]       = blue_m;
        vals[CFG_ALPHA_MASK]      = alpha_m;
        for (int k = 0; k < 8; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(k);
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly small dimensions; now and then zero, the maximum, a value up to
    // the maximum, or an arbitrary raw 16-bit value.
    function automatic logic [15:0] pick_dim(int small_max);
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1:       return 16'(MAX_DIM);
            2:       return 16'($urandom_range(0, 65535));
            3:       return 16'($urandom_range(1, MAX_DIM));
            default: return 16'($urandom_range(1, small_max));
        endcase
    endfunction

    // zero, all ones, a contiguous field anywhere, or arbitrary bits
    function automatic logic [15:0] pick_mask();
        int len;
        int sh;
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: begin
                len = $urandom_range(1, 16);
                sh  = $urandom_range(0, 16 - len);
                return 16'(((32'd1 << len) - 1) << sh);
            end
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One random setting followed by a byte stream. Mostly whole images
    // starting with image_start; some phases carry on from the counters of the
    // previous setting, get cut short, or see a stray image_start.
    task automatic random_phase();
        t_pixel_mode mode;
        logic        bf;
        int          w;
        int          h;
        int          bpp;
        int          nbytes;
        int          pause_at;
        bit          fresh;
        bit          start;
        case ($urandom_range(0, 9))
            0:       mode = MODE_NONE;
            1, 2, 3: mode = MODE_GREY8;
            4, 5, 6: mode = MODE_RGB16;
            default: mode = MODE_BGR24;
        endcase
        bf = ($urandom_range(0, 3) != 0);
        load_config(mode, pick_dim(8), pick_dim(3), bf,
                    pick_mask(), pick_mask(), pick_mask(), pick_mask());
        no_gaps = ($urandom_range(0, 3) == 0);
        fresh   = ($urandom_range(0, 3) != 0);
        if (mode == MODE_NONE) begin
            // ignored bytes, not counted
            nbytes = $urandom_range(1, 6);
        end else begin
            w      = pix_sb.width_px();
            h      = pix_sb.height_px();
            bpp    = pix_sb.bytes_per_pixel();
            nbytes = h * (w * bpp + pix_sb.row_pad()) * $urandom_range(1, 2);
            if (nbytes > 96)
                nbytes = $urandom_range(8, 96);  // big image: only its first rows
            if ($urandom_range(0, 4) == 0)
                nbytes = $urandom_range(1, nbytes);
            bytes_sent += nbytes;
        end
        pause_at = ($urandom_range(0, 5) == 0) ? nbytes / 2 : -1;
        for (int k = 0; k < nbytes; k++) begin
            start = (k == 0 && fresh) || ($urandom_range(0, 49) == 0);
            send_byte(8'($urandom_range(0, 255)), start);
            if (k == pause_at)
                wait_drain();
        end
        wait_drain();
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        pix_sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_PIXEL_MODE;
        i_cfg_wdata   <= '0;
        i_valid       <= 1'b0;
        i_data_byte   <= 8'h00;
        i_image_start <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting, 24-bit 1x1: one pixel, its padding byte, then the
        // counters wrap into a second image without image_start
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        wait_drain();

        // grey; width all ones saturates to the maximum, zero height means 1
        load_config(MODE_GREY8, 16'hFFFF, 16'h0000, 1'b0,
                    RED_555, GREEN_555, BLUE_555, 16'h0000);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        wait_drain();

        // grey, tallest image: first row index is height-1
        load_config(MODE_GREY8, 16'd4, 16'(MAX_DIM), 1'b0,
                    RED_555, GREEN_555, BLUE_555, 16'h0000);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_drain();

        // 5-5-5: all ones (bit 15 ignored), then red only
        load_config(MODE_RGB16, 16'd2, 16'd1, 1'b0,
                    RED_555, GREEN_555, BLUE_555, 16'h0000);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7C, 1'b0);
        wait_drain();

        // bitfields 5-6-5, no alpha mask so alpha is 255
        load_config(MODE_RGB16, 16'd2, 16'd1, 1'b1,
                    16'hF800, 16'h07E0, 16'h001F, 16'h0000);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'hA8, 1'b0);
        wait_drain();

        // bitfields: 16-bit wide red keeps its top bits, non-contiguous green,
        // zero blue mask, one-bit alpha
        load_config(MODE_RGB16, 16'd2, 16'd1, 1'b1,
                    16'hFFFF, 16'h0505, 16'h0000, 16'h8000);
        send_byte(8'h34, 1'b1);
        send_byte(8'h92, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        wait_drain();

        // unused mode: bytes are dropped, no pixel
        load_config(MODE_NONE, 16'd1, 16'd1, 1'b0,
                    RED_555, GREEN_555, BLUE_555, 16'h0000);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h3C, 1'b0);
        wait_drain();

        while (bytes_sent < RANDOM_BYTES)
            random_phase();

        no_gaps = 1'b0;
        wait_drain();
        if (pix_sb.errors == 0 && pix_sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bmpu_pkg.sv
hw/rtl/bmpu_cfg_regs.sv
hw/rtl/bmpu_assembler.sv
hw/rtl/bmpu_color.sv
hw/rtl/bmp_pixel_unpacker_unit.sv
tb/tb_bmp_pixel_unpacker_unit.sv
